// File: hdl/coarse_to_fine_focus_search_defines.svh
// assertion macros for the coarse-to-fine focus search
// used by the top level; expects clk and rst in the including scope
`ifndef COARSE_TO_FINE_FOCUS_SEARCH_DEFINES_SVH
`define COARSE_TO_FINE_FOCUS_SEARCH_DEFINES_SVH

// same-cycle implication
`define CFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/cfs_pkg.sv
// shared types, codes and defaults of the coarse-to-fine focus search
// no dependencies; used by all modules of the block
package cfs_pkg;

  localparam int Z_WIDTH_DEFAULT      = 32;
  localparam int METRIC_WIDTH_DEFAULT = 32;
  localparam int DIV_WIDTH            = 10;
  localparam int PASS_WIDTH           = 8;
  localparam int CFG_INDEX_WIDTH      = 2;

  // register reset values
  localparam longint RANGE_LOW_RESET  = 0;
  localparam longint RANGE_HIGH_RESET = 16777216;
  localparam logic [DIV_WIDTH-1:0]  DIVISIONS_RESET = 10'd10;
  localparam logic [PASS_WIDTH-1:0] PASSES_RESET    = 8'd3;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIVISIONS  = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PASSES     = 2'd3;

  localparam logic FUNC_START = 1'b0;

  typedef logic [1:0] status_t;
  localparam status_t ST_NEXT  = 2'd0;
  localparam status_t ST_FOUND = 2'd1;
  localparam status_t ST_NONE  = 2'd2;
  localparam status_t ST_IDLE  = 2'd3;

  typedef logic [1:0] zsel_t;
  localparam zsel_t ZSEL_CUR  = 2'd0;
  localparam zsel_t ZSEL_BEST = 2'd1;
  localparam zsel_t ZSEL_ZERO = 2'd2;

  typedef struct packed {
    logic    capture;
    logic    start_search;
    logic    sample;
    logic    narrow;
    logic    restart;
    logic    stop_run;
    logic    div_go;
    logic    out_load;
    zsel_t   out_zsel;
    status_t out_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic func;
    logic running;
    logic cont;
    logic have_best;
    logic more;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

// File: hdl/cfs_div.sv
// serial signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero
// depends on cfs_pkg
module cfs_div #(
  parameter int N = cfs_pkg::Z_WIDTH_DEFAULT + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic signed [N-1:0]            dividend,
  input  logic [cfs_pkg::DIV_WIDTH-1:0]  divisor,
  output logic                           done,
  output logic signed [N-1:0]            quotient
);

  localparam int DW    = cfs_pkg::DIV_WIDTH;
  localparam int CNT_W = $clog2(N + 1);

  logic [N-1:0]     mag;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dsor;
  logic             neg;
  logic [CNT_W-1:0] count;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             q_bit;
  logic [DW-1:0]    rem_next;

  assign trial    = {rem, mag[N-1]};
  assign diff     = trial - {1'b0, dsor};
  assign q_bit    = (trial >= {1'b0, dsor});
  assign rem_next = q_bit ? diff[DW-1:0] : trial[DW-1:0];
  assign quotient = neg ? $signed(-mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        count <= CNT_W'(N);
      end else if (count != '0) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      neg  <= dividend[N-1];
      mag  <= dividend[N-1] ? -dividend : dividend;
      rem  <= '0;
      dsor <= divisor;
    end else if (count != '0) begin
      rem <= rem_next;
      mag <= {mag[N-2:0], q_bit};
    end
  end

endmodule

// File: hdl/cfs_datapath.sv
// datapath: config registers, search state, step divider and output register
// depends on cfs_pkg and cfs_div
module cfs_datapath #(
  parameter int Z_WIDTH      = cfs_pkg::Z_WIDTH_DEFAULT,
  parameter int METRIC_WIDTH = cfs_pkg::METRIC_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // config writes
  input  logic                                 cfg_valid,
  input  logic [cfs_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [Z_WIDTH-1:0]                   cfg_data,
  // input item fields
  input  logic                                 in_func,
  input  logic [METRIC_WIDTH-1:0]              in_metric,
  input  logic                                 in_metric_valid,
  input  logic                                 in_stop,
  // result
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [Z_WIDTH-1:0]                   out_z,
  output cfs_pkg::status_t                     out_status,
  input  cfs_pkg::ctrl_cmd_t                   cmd,
  output cfs_pkg::dp_sts_t                     sts
);

  localparam int DW = cfs_pkg::DIV_WIDTH;
  localparam int PW = cfs_pkg::PASS_WIDTH;

  localparam logic signed [Z_WIDTH+1:0] WIDE_MAX = {3'b000, {(Z_WIDTH-1){1'b1}}};
  localparam logic signed [Z_WIDTH+1:0] WIDE_MIN = {3'b111, {(Z_WIDTH-1){1'b0}}};
  localparam logic signed [Z_WIDTH-1:0] Z_MAX    = {1'b0, {(Z_WIDTH-1){1'b1}}};
  localparam logic signed [Z_WIDTH-1:0] Z_MIN    = {1'b1, {(Z_WIDTH-1){1'b0}}};

  function automatic logic signed [Z_WIDTH-1:0] sat_z(input logic signed [Z_WIDTH+1:0] v);
    if (v > WIDE_MAX) begin
      sat_z = Z_MAX;
    end else if (v < WIDE_MIN) begin
      sat_z = Z_MIN;
    end else begin
      sat_z = v[Z_WIDTH-1:0];
    end
  endfunction

  // config registers
  logic [Z_WIDTH-1:0] range_low;
  logic [Z_WIDTH-1:0] range_high;
  logic [DW-1:0]      divisions;
  logic [PW-1:0]      passes;

  // captured item
  logic                    item_func;
  logic [METRIC_WIDTH-1:0] item_metric;
  logic                    item_metric_valid;
  logic                    item_stop;

  // search state
  logic                           running;
  logic signed [Z_WIDTH-1:0]      current_z;
  logic signed [Z_WIDTH-1:0]      sweep_low;
  logic signed [Z_WIDTH-1:0]      sweep_high;
  logic signed [Z_WIDTH:0]        step_size;
  logic [METRIC_WIDTH-1:0]        best_metric;
  logic signed [Z_WIDTH-1:0]      best_z;
  logic                           have_best;
  logic [PW-1:0]                  passes_left;

  logic signed [Z_WIDTH-1:0] step_z;
  logic signed [Z_WIDTH-1:0] narrow_low;
  logic signed [Z_WIDTH-1:0] narrow_high;
  logic signed [Z_WIDTH:0]   span;
  logic [DW-1:0]             div_d;
  logic                      div_done;
  logic signed [Z_WIDTH:0]   div_q;
  logic                      better;

  assign step_z = sat_z($signed({{2{current_z[Z_WIDTH-1]}}, current_z})
                        + $signed({step_size[Z_WIDTH], step_size}));
  assign narrow_low = sat_z($signed({{2{best_z[Z_WIDTH-1]}}, best_z})
                            - $signed({step_size[Z_WIDTH], step_size}));
  assign narrow_high = sat_z($signed({{2{best_z[Z_WIDTH-1]}}, best_z})
                             + $signed({step_size[Z_WIDTH], step_size}));
  assign span  = $signed({sweep_high[Z_WIDTH-1], sweep_high})
               - $signed({sweep_low[Z_WIDTH-1], sweep_low});
  // zero divisions acts as one
  assign div_d  = (divisions == '0) ? DW'(1) : divisions;
  assign better = item_metric_valid && (!have_best || (item_metric > best_metric));

  cfs_div #(
    .N (Z_WIDTH + 1)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (span),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= Z_WIDTH'(cfs_pkg::RANGE_LOW_RESET);
      range_high <= Z_WIDTH'(cfs_pkg::RANGE_HIGH_RESET);
      divisions  <= cfs_pkg::DIVISIONS_RESET;
      passes     <= cfs_pkg::PASSES_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        cfs_pkg::REG_RANGE_LOW:  range_low  <= cfg_data;
        cfs_pkg::REG_RANGE_HIGH: range_high <= cfg_data;
        cfs_pkg::REG_DIVISIONS:  divisions  <= cfg_data[DW-1:0];
        cfs_pkg::REG_PASSES:     passes     <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_func         <= in_func;
      item_metric       <= in_metric;
      item_metric_valid <= in_metric_valid;
      item_stop         <= in_stop;
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      have_best <= 1'b0;
    end else begin
      if (cmd.start_search) begin
        running   <= 1'b1;
        have_best <= 1'b0;
      end
      if (cmd.sample && better) begin
        have_best <= 1'b1;
      end
      if (cmd.restart) begin
        have_best <= 1'b0;
      end
      if (cmd.stop_run) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_search) begin
      sweep_low   <= range_low;
      sweep_high  <= range_high;
      current_z   <= range_low;
      passes_left <= (passes == '0) ? PW'(1) : passes;
      best_metric <= '0;
      best_z      <= '0;
    end
    if (cmd.sample) begin
      if (better) begin
        best_metric <= item_metric;
        best_z      <= current_z;
      end
      current_z <= step_z;
    end
    if (cmd.narrow) begin
      sweep_low   <= narrow_low;
      sweep_high  <= narrow_high;
      passes_left <= passes_left - PW'(1);
    end
    if (cmd.restart) begin
      current_z   <= sweep_low;
      best_metric <= '0;
    end
    if (div_done) begin
      step_size <= div_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_status;
      case (cmd.out_zsel)
        cfs_pkg::ZSEL_CUR:  out_z <= current_z;
        cfs_pkg::ZSEL_BEST: out_z <= best_z;
        default:            out_z <= '0;
      endcase
    end
  end

  assign sts.func      = item_func;
  assign sts.running   = running;
  assign sts.cont      = !item_stop && (current_z <= sweep_high);
  assign sts.have_best = have_best;
  assign sts.more      = (passes_left != '0) && !item_stop;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid || out_ready;

endmodule

// File: hdl/cfs_ctrl.sv
// controller state machine sequencing one item at a time through the datapath
// depends on cfs_pkg
module cfs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cfs_pkg::dp_sts_t   sts,
  output cfs_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SAMPLE   = 3'd2;
  localparam logic [2:0] S_CHECK    = 3'd3;
  localparam logic [2:0] S_DECIDE   = 3'd4;
  localparam logic [2:0] S_LAUNCH   = 3'd5;
  localparam logic [2:0] S_DIV      = 3'd6;
  localparam logic [2:0] S_EMIT     = 3'd7;

  logic [2:0]       state;
  logic [2:0]       state_next;
  cfs_pkg::zsel_t   pend_zsel;
  cfs_pkg::zsel_t   pend_zsel_next;
  cfs_pkg::status_t pend_status;
  cfs_pkg::status_t pend_status_next;

  // nothing is taken while reset is held
  assign in_ready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_zsel   <= pend_zsel_next;
    pend_status <= pend_status_next;
  end

  always_comb begin
    state_next       = state;
    pend_zsel_next   = pend_zsel;
    pend_status_next = pend_status;
    cmd              = '0;
    cmd.out_zsel     = pend_zsel;
    cmd.out_status   = pend_status;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.func == cfs_pkg::FUNC_START) begin
          cmd.start_search = 1'b1;
          pend_zsel_next   = cfs_pkg::ZSEL_CUR;
          pend_status_next = cfs_pkg::ST_NEXT;
          state_next       = S_LAUNCH;
        end else if (!sts.running) begin
          pend_zsel_next   = cfs_pkg::ZSEL_ZERO;
          pend_status_next = cfs_pkg::ST_IDLE;
          state_next       = S_EMIT;
        end else begin
          state_next = S_SAMPLE;
        end
      end
      S_SAMPLE: begin
        cmd.sample = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.cont) begin
          pend_zsel_next   = cfs_pkg::ZSEL_CUR;
          pend_status_next = cfs_pkg::ST_NEXT;
          state_next       = S_EMIT;
        end else if (!sts.have_best) begin
          // sweep ended without any valid sample
          cmd.stop_run     = 1'b1;
          pend_zsel_next   = cfs_pkg::ZSEL_ZERO;
          pend_status_next = cfs_pkg::ST_NONE;
          state_next       = S_EMIT;
        end else begin
          cmd.narrow = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.more) begin
          cmd.restart      = 1'b1;
          pend_zsel_next   = cfs_pkg::ZSEL_CUR;
          pend_status_next = cfs_pkg::ST_NEXT;
          state_next       = S_LAUNCH;
        end else begin
          cmd.stop_run     = 1'b1;
          pend_zsel_next   = cfs_pkg::ZSEL_BEST;
          pend_status_next = cfs_pkg::ST_FOUND;
          state_next       = S_EMIT;
        end
      end
      S_LAUNCH: begin
        cmd.div_go = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/coarse_to_fine_focus_search.sv
// Coarse-to-fine autofocus search. A start transaction (tuser func = 0) loads the
// configured range and returns its low end as the first focus distance; each sample
// transaction returns the next distance, or the final one when the passes run out
// or a stop is requested; a sample while no search runs, or one that ends a sweep
// without any valid sample, returns zero. A start and a sample that opens a new
// sweep run the step divider, which produces one quotient bit per cycle. One item
// is in flight at a time; a finished result waits in the output register while the
// next item is taken. Configuration writes are accepted whenever reset is released
// and must only be issued while the block is idle.
// depends on cfs_pkg, cfs_ctrl, cfs_datapath and the defines header
`include "coarse_to_fine_focus_search_defines.svh"

module coarse_to_fine_focus_search #(
  parameter int Z_WIDTH      = cfs_pkg::Z_WIDTH_DEFAULT,
  parameter int METRIC_WIDTH = cfs_pkg::METRIC_WIDTH_DEFAULT,
  localparam int IN_DATA_W   = ((METRIC_WIDTH + 1 + 7) / 8) * 8,
  localparam int OUT_DATA_W  = ((Z_WIDTH + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cfs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [Z_WIDTH-1:0]                  cfg_data,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [IN_DATA_W-1:0]                s_tdata,   // metric, stop_request, zero fill
  input  logic [1:0]                          s_tuser,   // func, metric_valid
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [OUT_DATA_W-1:0]               m_tdata,   // focus_z, zero fill
  output logic [1:0]                          m_tuser    // status
);

  cfs_pkg::ctrl_cmd_t cmd;
  cfs_pkg::dp_sts_t   sts;
  logic [Z_WIDTH-1:0] out_z;
  cfs_pkg::status_t   out_status;

  assign cfg_ready = !rst;
  assign m_tdata   = OUT_DATA_W'(out_z);
  assign m_tuser   = out_status;

  cfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfs_datapath #(
    .Z_WIDTH      (Z_WIDTH),
    .METRIC_WIDTH (METRIC_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_func         (s_tuser[0]),
    .in_metric       (s_tdata[METRIC_WIDTH-1:0]),
    .in_metric_valid (s_tuser[1]),
    .in_stop         (s_tdata[METRIC_WIDTH]),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_z           (out_z),
    .out_status      (out_status),
    .cmd             (cmd),
    .sts             (sts)
  );

  // only one item in flight
  `CFS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "item accepted while busy")
  // a loaded result shows up on the output
  `CFS_ASSERT_NEXT(a_load_shows, cmd.out_load, m_tvalid, "loaded result not presented")
  // measure-next results come only from a running search, all others only while no search runs
  `CFS_ASSERT_NOW(a_status_run, cmd.out_load,
                  (cmd.out_status == cfs_pkg::ST_NEXT) == sts.running,
                  "result status disagrees with search state")

endmodule
